// ----- rtl/bspce_pkg.sv -----
// Shared types, constants and helpers for the B-spline curve point evaluator.
`default_nettype none
package bspce_pkg;

  localparam int MAX_DEGREE = 7;
  localparam int MAX_POINTS = 64;
  localparam int KNOT_DEPTH = 72;
  localparam int KNOT_AW    = $clog2(KNOT_DEPTH);
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int DEG_W      = 3;
  localparam int CNT_W      = 7;
  localparam int IDX_W      = 7;
  localparam int BAS_AW     = $clog2(MAX_DEGREE + 1);
  localparam int S_TDATA_W  = 168;
  localparam int M_TDATA_W  = 104;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  localparam logic [1:0] CMD_KNOT  = 2'd0;
  localparam logic [1:0] CMD_POINT = 2'd1;
  localparam logic [1:0] CMD_EVAL  = 2'd2;

  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_LAST, S_SCAN_RD, S_SCAN_CMP, S_LF_RD, S_RT_RD, S_RT_CAP,
    S_DSUM, S_DIV_A, S_DIV_B, S_MUL_A, S_MUL_B, S_UPD,
    S_OUT_RD, S_OUT_X, S_OUT_Y, S_OUT_Z, S_OUT_ACC, S_FIN
  } st_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] knot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] u;
  } req_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [IDX_W-1:0]   span;
  } res_t;

  typedef struct packed {
    logic [DEG_W-1:0] deg;
    logic [CNT_W-1:0] cnt;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] num;
    logic signed [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bspce_div.sv -----
// Radix-2 restoring divider giving a saturated Q2.30 ratio num / den.
`default_nettype none
module bspce_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bspce_pkg::div_req_t req,
  output bspce_pkg::div_rsp_t      rsp
);
  import bspce_pkg::*;

  logic        busy, done_q, neg_q, ovf_q;
  logic [5:0]  cnt_q;
  logic [33:0] rem_q, dmag_q;
  logic [62:0] dvd_q;
  logic [32:0] q_q;
  logic [32:0] num_mag;
  logic [33:0] den_mag;
  logic [34:0] rem_sh, diff;
  logic        ge, big_pos, big_neg;
  logic [32:0] q_neg;

  assign num_mag = req.num[32] ? (~req.num + 33'd1) : req.num;
  assign den_mag = req.den[33] ? (~req.den + 34'd1) : req.den;
  assign rem_sh  = {rem_q, dvd_q[62]};
  assign diff    = rem_sh - {1'b0, dmag_q};
  assign ge      = rem_sh >= {1'b0, dmag_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        cnt_q  <= 6'd62;
        rem_q  <= '0;
        q_q    <= '0;
        ovf_q  <= 1'b0;
        dmag_q <= den_mag;
        dvd_q  <= {num_mag, 30'b0};
        neg_q  <= req.num[32] ^ req.den[33];
      end else if (busy) begin
        rem_q <= ge ? diff[33:0] : rem_sh[33:0];
        q_q   <= {q_q[31:0], ge};
        ovf_q <= ovf_q | q_q[32];
        dvd_q <= {dvd_q[61:0], 1'b0};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // A negative ratio may reach exactly -2.0, a positive one stops one below.
  assign big_pos = ovf_q | q_q[32] | q_q[31];
  assign big_neg = ovf_q | q_q[32] | (q_q[31] & (|q_q[30:0]));
  assign q_neg   = ~q_q + 33'd1;

  always_comb begin
    rsp.done = done_q;
    if (neg_q) rsp.quo = big_neg ? 32'sh8000_0000 : q_neg[31:0];
    else       rsp.quo = big_pos ? 32'sh7FFF_FFFF : q_q[31:0];
  end

endmodule
`default_nettype wire

// ----- rtl/bspce_core.sv -----
// Knot and control-point memories with the span search and Cox-de Boor sequencer.
`default_nettype none
module bspce_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bspce_pkg::req_t     req,
  input  wire logic                req_valid,
  input  wire bspce_pkg::cfg_t     cfg,
  input  wire logic                out_free,
  output logic                     idle,
  output logic                     res_valid,
  output bspce_pkg::res_t          res,
  output bspce_pkg::div_req_t      dreq,
  input  wire bspce_pkg::div_rsp_t drsp
);
  import bspce_pkg::*;

  st_t state, state_next;

  logic signed [31:0] knot_mem [KNOT_DEPTH];
  logic signed [31:0] cx_mem [MAX_POINTS];
  logic signed [31:0] cy_mem [MAX_POINTS];
  logic signed [31:0] cz_mem [MAX_POINTS];
  logic signed [31:0] knot_q, cx_q, cy_q, cz_q;
  logic               knot_rd, pt_rd;
  logic [KNOT_AW-1:0] knot_raddr;
  logic [PT_AW-1:0]   pt_raddr;
  logic [IDX_W-1:0]   pt_full;

  logic signed [31:0] u_q;
  logic [DEG_W-1:0]   p_q;
  logic [CNT_W-1:0]   n_q, k_q, span_q;
  logic [BAS_AW-1:0]  j_q, r_q, i_q;
  logic signed [32:0] lf [MAX_DEGREE + 1];
  logic signed [32:0] rt [MAX_DEGREE + 1];
  logic signed [31:0] basis [MAX_DEGREE + 1];
  logic signed [33:0] d_q, d_comb, ta_q, saved_q, tb_c;
  logic signed [31:0] ra_q, rb_q, mul_a, mul_b;
  logic signed [63:0] prod_q;
  logic signed [53:0] acc_x, acc_y, acc_z;

  assign d_comb  = 34'(rt[r_q + 3'd1]) + 34'(lf[j_q - r_q]);
  assign tb_c    = 34'(prod_q >>> 30);
  assign pt_full = span_q - 7'(p_q) + 7'(i_q);
  assign idle    = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    knot_rd    = 1'b0;
    knot_raddr = '0;
    pt_rd      = 1'b0;
    pt_raddr   = '0;
    dreq       = '0;
    mul_a      = '0;
    mul_b      = '0;
    res_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid && req.cmd == CMD_EVAL) begin
          knot_rd    = 1'b1;
          knot_raddr = KNOT_AW'(cfg.cnt);
          state_next = S_LAST;
        end
      end
      S_LAST: state_next = (u_q >= knot_q) ? S_LF_RD : S_SCAN_RD;
      S_SCAN_RD: begin
        knot_rd    = 1'b1;
        knot_raddr = KNOT_AW'(k_q);
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: state_next = (knot_q > u_q) ? S_LF_RD : S_SCAN_RD;
      S_LF_RD: begin
        knot_rd    = 1'b1;
        knot_raddr = KNOT_AW'(span_q + 7'd1 - 7'(j_q));
        state_next = S_RT_RD;
      end
      S_RT_RD: begin
        knot_rd    = 1'b1;
        knot_raddr = KNOT_AW'(span_q + 7'(j_q));
        state_next = S_RT_CAP;
      end
      S_RT_CAP: state_next = S_DSUM;
      S_DSUM: begin
        if (d_comb != 34'sd0) begin
          dreq.start = 1'b1;
          dreq.num   = rt[r_q + 3'd1];
          dreq.den   = d_comb;
          state_next = S_DIV_A;
        end else begin
          state_next = S_MUL_A;
        end
      end
      S_DIV_A: begin
        if (drsp.done) begin
          dreq.start = 1'b1;
          dreq.num   = lf[j_q - r_q];
          dreq.den   = d_q;
          state_next = S_DIV_B;
        end
      end
      S_DIV_B: if (drsp.done) state_next = S_MUL_A;
      S_MUL_A: begin
        mul_a      = basis[r_q];
        mul_b      = ra_q;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        mul_a      = basis[r_q];
        mul_b      = rb_q;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (r_q == j_q - 3'd1) state_next = (j_q == p_q) ? S_OUT_RD : S_LF_RD;
        else                   state_next = S_DSUM;
      end
      S_OUT_RD: begin
        pt_rd      = 1'b1;
        pt_raddr   = pt_full[PT_AW-1:0];
        state_next = S_OUT_X;
      end
      S_OUT_X: begin
        mul_a      = cx_q;
        mul_b      = basis[i_q];
        state_next = S_OUT_Y;
      end
      S_OUT_Y: begin
        mul_a      = cy_q;
        mul_b      = basis[i_q];
        state_next = S_OUT_Z;
      end
      S_OUT_Z: begin
        mul_a      = cz_q;
        mul_b      = basis[i_q];
        state_next = S_OUT_ACC;
      end
      S_OUT_ACC: state_next = (i_q == p_q) ? S_FIN : S_OUT_RD;
      S_FIN: begin
        res_valid = 1'b1;
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Table writes arrive only while the sequencer is idle.
  always_ff @(posedge clk) begin
    if (idle && req_valid) begin
      case (req.cmd)
        CMD_KNOT: begin
          if (req.idx < IDX_W'(KNOT_DEPTH)) knot_mem[req.idx[KNOT_AW-1:0]] <= req.knot;
        end
        CMD_POINT: begin
          if (req.idx < IDX_W'(MAX_POINTS)) begin
            cx_mem[req.idx[PT_AW-1:0]] <= req.x;
            cy_mem[req.idx[PT_AW-1:0]] <= req.y;
            cz_mem[req.idx[PT_AW-1:0]] <= req.z;
          end
        end
        default: ;
      endcase
    end
    if (knot_rd) knot_q <= knot_mem[knot_raddr];
    if (pt_rd) begin
      cx_q <= cx_mem[pt_raddr];
      cy_q <= cy_mem[pt_raddr];
      cz_q <= cz_mem[pt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        u_q      <= req.u;
        p_q      <= cfg.deg;
        n_q      <= cfg.cnt;
        k_q      <= 7'(cfg.deg) + 7'd1;
        j_q      <= 3'd1;
        basis[0] <= ONE_Q30;
      end
      S_LAST: if (u_q >= knot_q) span_q <= n_q - 7'd1;
      S_SCAN_CMP: begin
        if (knot_q > u_q) span_q <= k_q - 7'd1;
        else              k_q    <= k_q + 7'd1;
      end
      S_RT_RD: lf[j_q] <= 33'(u_q) - 33'(knot_q);
      S_RT_CAP: begin
        rt[j_q] <= 33'(knot_q) - 33'(u_q);
        r_q     <= '0;
        saved_q <= '0;
      end
      S_DSUM: begin
        d_q  <= d_comb;
        ra_q <= '0;
        rb_q <= '0;
      end
      S_DIV_A: if (drsp.done) ra_q <= drsp.quo;
      S_DIV_B: if (drsp.done) rb_q <= drsp.quo;
      S_MUL_B: ta_q <= tb_c;
      S_UPD: begin
        basis[r_q] <= sat32(64'(saved_q) + 64'(ta_q));
        saved_q    <= tb_c;
        r_q        <= r_q + 3'd1;
        if (r_q == j_q - 3'd1) begin
          basis[j_q] <= sat32(64'(tb_c));
          j_q        <= j_q + 3'd1;
          i_q        <= '0;
          acc_x      <= '0;
          acc_y      <= '0;
          acc_z      <= '0;
        end
      end
      S_OUT_Y: acc_x <= acc_x + 54'(prod_q >>> 14);
      S_OUT_Z: acc_y <= acc_y + 54'(prod_q >>> 14);
      S_OUT_ACC: begin
        acc_z <= acc_z + 54'(prod_q >>> 14);
        i_q   <= i_q + 3'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.x    = sat32(64'((acc_x + 54'sd32768) >>> 16));
    res.y    = sat32(64'((acc_y + 54'sd32768) >>> 16));
    res.z    = sat32(64'((acc_z + 54'sd32768) >>> 16));
    res.span = span_q;
  end

endmodule
`default_nettype wire

// ----- rtl/bspline_curve_point_eval.sv -----
// B-spline curve point evaluator (Cox-de Boor): top level with ports and configuration.
//
// Input words on s_axis carry a command in tuser: write a knot, write a control
// point, or evaluate the curve at param_u. Writes give no output word. An
// evaluation gives one output word on m_axis with x, y, z and the knot span
// used. The cfg channel sets degree and point count; it is always ready, and
// it is to be written only while the block is idle; the block itself does not
// enforce this. Evaluation runs on one knot memory and one control-point
// memory through a single sequencer, one shared divider and one multiplier.
// It first scans the knots for the span, then per basis step runs two 63-step
// divisions per term (skipped when the knot differences sum to zero), then
// forms the weighted sum of the control points and hands the result over.
// One item is evaluated at a time. The result sits in an output register, so
// the next item may be taken while it waits; a stalled receiver holds the
// sequencer only at the hand-over point. Reset clears the control state and
// sets degree 3 and four points; the tables are undefined until written.
`default_nettype none
module bspline_curve_point_eval (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // entry_index, knot_value, coord_x, coord_y, coord_z, param_u, zero pad
  input  wire logic [bspce_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // cmd
  input  wire logic [1:0]                           s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // pos_x, pos_y, pos_z, span_found, zero pad
  output logic [bspce_pkg::M_TDATA_W-1:0]           m_axis_tdata,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic                                 cfg_index,
  input  wire logic [bspce_pkg::CNT_W-1:0]          cfg_data
);
  import bspce_pkg::*;

  logic [DEG_W-1:0] deg_reg, p_cl;
  logic [CNT_W-1:0] cnt_reg, n_cl;
  cfg_t             eff;
  req_t             req;
  res_t             res;
  div_req_t         dreq;
  div_rsp_t         drsp;
  logic             idle, res_valid, out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_reg <= 3'd3;
      cnt_reg <= 7'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEGREE: deg_reg <= cfg_data[DEG_W-1:0];
        CFG_COUNT:  cnt_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the registers to a usable curve before the sequencer sees them.
  always_comb begin
    p_cl = (deg_reg == '0) ? 3'd1 :
           (deg_reg > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_reg;
    n_cl = (cnt_reg < 7'd2) ? 7'd2 :
           (cnt_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cnt_reg;
    eff.cnt = n_cl;
    eff.deg = (7'(p_cl) > n_cl - 7'd1) ? DEG_W'(n_cl - 7'd1) : p_cl;
  end

  always_comb begin
    req.cmd  = s_axis_tuser;
    req.idx  = s_axis_tdata[6:0];
    req.knot = s_axis_tdata[38:7];
    req.x    = s_axis_tdata[70:39];
    req.y    = s_axis_tdata[102:71];
    req.z    = s_axis_tdata[134:103];
    req.u    = s_axis_tdata[166:135];
  end

  assign s_axis_tready = idle;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  bspce_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (s_axis_tvalid),
    .cfg       (eff),
    .out_free  (out_free),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .dreq      (dreq),
    .drsp      (drsp)
  );

  bspce_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) m_axis_tdata <= {1'b0, res.span, res.z, res.y, res.x};
  end

`ifndef SYNTH
  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_free) |=> m_axis_tvalid)
    else $error("finished word was not presented on the output");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !s_axis_tready)
    else $error("input taken while a result is pending");

  a_span_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.span < eff.cnt) && (res.span >= 7'(eff.deg)))
    else $error("knot span outside the usable range");
`endif

endmodule
`default_nettype wire
